/* src/mabr_pkg.sv */
// ----------------------------------------------------------------------------
// mabr_pkg: shared types and constants for the baseline removal block
// Window geometry, arithmetic widths, the divide-by-window reciprocal and
// the item and stage structs used between the modules.
// ----------------------------------------------------------------------------
package mabr_pkg;

  localparam int HALF_WINDOW = 20;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
  localparam int WIN_LOG     = $clog2(WIN_LEN);

  // Magnitude of a window sum stays below 2**MAG_BITS.
  localparam int MAG_BITS  = SAMPLE_BITS - 1 + WIN_LOG;
  localparam int SUM_BITS  = MAG_BITS + 1;

  // floor(mag / WIN_LEN) == (mag * DIV_MULT) >> DIV_SHIFT for every mag
  // below 2**MAG_BITS, with DIV_MULT = ceil(2**DIV_SHIFT / WIN_LEN).
  localparam int DIV_SHIFT = MAG_BITS + WIN_LOG;
  localparam int MULT_BITS = MAG_BITS + 1;
  localparam int PROD_BITS = MAG_BITS + MULT_BITS;
  localparam longint unsigned DIV_MULT_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN);
  localparam logic [MULT_BITS-1:0] DIV_MULT = MULT_BITS'(DIV_MULT_FULL);

  localparam logic signed [SUM_BITS-1:0] WIN_LEN_S = SUM_BITS'(WIN_LEN);

  localparam int POS_BITS   = $clog2(HALF_WINDOW + 1);
  localparam int FLUSH_BITS = $clog2(HALF_WINDOW + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_record;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] corrected;
    logic                        last_result;
  } out_item_t;

  // One classified sample on its way to the window stage.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
    logic                          last;
  } op_t;

  // Centre sample and window sum of one result, before the divide.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] centre;
    logic signed [SUM_BITS-1:0]    sum;
    logic                          last_result;
  } win_res_t;

  typedef struct packed {
    logic flushing;
    logic pop;
  } win_stat_t;

endpackage

/* src/mabr_front.sv */
// ----------------------------------------------------------------------------
// mabr_front: input classification
// Marks each accepted sample as the first and/or last of its record.
// ----------------------------------------------------------------------------
module mabr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                smp_valid,
  output logic                smp_ready,
  input  mabr_pkg::in_item_t  smp_item,
  output logic                op_valid,
  input  logic                op_ready,
  output mabr_pkg::op_t       op
);

  logic in_record;

  always_comb begin
    op_valid  = smp_valid;
    smp_ready = op_ready;
    op.sample = smp_item.sample;
    op.first  = !in_record;
    op.last   = smp_item.end_of_record;
  end

  // A record is open from its first sample until its last one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_record <= 1'b0;
    end else if (smp_valid && op_ready) begin
      in_record <= !smp_item.end_of_record;
    end
  end

endmodule

/* src/mabr_queue.sv */
// ----------------------------------------------------------------------------
// mabr_queue: short item queue
// Decouples the input side from the window stage so each can stall alone.
// ----------------------------------------------------------------------------
module mabr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mabr_pkg::op_t  push_item,
  output logic           pop_valid,
  input  logic           pop,
  output mabr_pkg::op_t  pop_item
);

  mabr_pkg::op_t                  entries [mabr_pkg::QUEUE_DEPTH];
  logic [mabr_pkg::PTR_BITS-1:0]  wr_ptr;
  logic [mabr_pkg::PTR_BITS-1:0]  rd_ptr;
  logic [mabr_pkg::CNT_BITS-1:0]  count;
  logic                           do_push;
  logic                           do_pop;

  always_comb begin
    push_ready = count != mabr_pkg::CNT_BITS'(mabr_pkg::QUEUE_DEPTH);
    pop_valid  = count != '0;
    pop_item   = entries[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop && pop_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mabr_pkg::PTR_BITS'(mabr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mabr_pkg::PTR_BITS'(mabr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/mabr_window.sv */
// ----------------------------------------------------------------------------
// mabr_window: delay line and running window sum
// Keeps the latest window of samples as a shift line, padded with the first
// sample at record start and the last sample during the end-of-record flush.
// ----------------------------------------------------------------------------
module mabr_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  input  mabr_pkg::op_t        op,
  output logic                 op_pop,
  output logic                 res_valid,
  output mabr_pkg::win_res_t   res,
  input  logic                 res_ready,
  output mabr_pkg::win_stat_t  stat
);

  logic signed [mabr_pkg::SAMPLE_BITS-1:0] taps      [mabr_pkg::WIN_LEN];
  logic signed [mabr_pkg::SAMPLE_BITS-1:0] taps_next [mabr_pkg::WIN_LEN];
  logic signed [mabr_pkg::SUM_BITS-1:0]    sum;
  logic signed [mabr_pkg::SUM_BITS-1:0]    sum_next;
  logic [mabr_pkg::POS_BITS-1:0]           pos;
  logic [mabr_pkg::POS_BITS-1:0]           pos_next;
  logic [mabr_pkg::FLUSH_BITS-1:0]         flush_cnt;
  logic [mabr_pkg::FLUSH_BITS-1:0]         flush_cnt_next;
  logic                                    flushing;
  logic                                    step;
  logic                                    load;
  logic                                    emit;
  logic                                    res_valid_next;
  logic signed [mabr_pkg::SAMPLE_BITS-1:0] push_val;

  always_comb begin
    flushing = flush_cnt != '0;
    step     = (flushing || op_valid) && (!res_valid || res_ready);
    op_pop   = step && !flushing;
    load     = op_pop && op.first;
    // During the flush the newest sample is pushed again and again.
    push_val = flushing ? taps[0] : op.sample;

    taps_next[0] = push_val;
    for (int i = 1; i < mabr_pkg::WIN_LEN; i++) begin
      taps_next[i] = load ? push_val : taps[i-1];
    end

    if (load) begin
      sum_next = mabr_pkg::SUM_BITS'(push_val) * mabr_pkg::WIN_LEN_S;
      pos_next = mabr_pkg::POS_BITS'(1);
    end else begin
      sum_next = sum + mabr_pkg::SUM_BITS'(push_val)
                 - mabr_pkg::SUM_BITS'(taps[mabr_pkg::WIN_LEN-1]);
      pos_next = (pos == mabr_pkg::POS_BITS'(mabr_pkg::HALF_WINDOW)) ?
                 pos : pos + 1'b1;
    end

    // A result exists once the centre tap holds a real sample.
    emit = step && !load && (pos == mabr_pkg::POS_BITS'(mabr_pkg::HALF_WINDOW));

    if (op_pop && op.last) begin
      flush_cnt_next = mabr_pkg::FLUSH_BITS'(mabr_pkg::HALF_WINDOW);
    end else if (step && flushing) begin
      flush_cnt_next = flush_cnt - 1'b1;
    end else begin
      flush_cnt_next = flush_cnt;
    end

    res_valid_next = step ? emit : (res_valid && !res_ready);
    stat.flushing  = flushing;
    stat.pop       = op_pop;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      taps <= taps_next;
    end
    if (step && emit) begin
      res.centre      <= taps_next[mabr_pkg::HALF_WINDOW];
      res.sum         <= sum_next;
      res.last_result <= flushing && (flush_cnt == mabr_pkg::FLUSH_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      pos       <= '0;
      flush_cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        sum <= sum_next;
        pos <= pos_next;
      end
      flush_cnt <= flush_cnt_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

/* src/mabr_correct.sv */
// ----------------------------------------------------------------------------
// mabr_correct: mean and baseline subtraction
// Divides the window sum by the window length (reciprocal multiply,
// truncating toward zero) and subtracts it from the centre sample.
// ----------------------------------------------------------------------------
module mabr_correct (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mabr_pkg::win_res_t   in_res,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mabr_pkg::out_item_t  res_item
);

  logic                                    s1_valid;
  logic signed [mabr_pkg::SAMPLE_BITS-1:0] s1_centre;
  logic                                    s1_neg;
  logic [mabr_pkg::PROD_BITS-1:0]          s1_prod;
  logic                                    s1_last;
  logic                                    out_free;
  logic [mabr_pkg::MAG_BITS-1:0]           mag;
  logic [mabr_pkg::PROD_BITS-1:0]          prod;
  logic [mabr_pkg::SAMPLE_BITS:0]          quot;
  logic [mabr_pkg::SAMPLE_BITS:0]          mean;
  logic [mabr_pkg::SAMPLE_BITS:0]          diff;

  always_comb begin
    out_free = !res_valid || res_ready;
    in_ready = !s1_valid || out_free;
    mag  = in_res.sum[mabr_pkg::SUM_BITS-1] ? mabr_pkg::MAG_BITS'(-in_res.sum) :
                                              mabr_pkg::MAG_BITS'(in_res.sum);
    prod = mabr_pkg::PROD_BITS'(mag) * mabr_pkg::PROD_BITS'(mabr_pkg::DIV_MULT);
    quot = {1'b0, s1_prod[mabr_pkg::DIV_SHIFT +: mabr_pkg::SAMPLE_BITS]};
    mean = s1_neg ? -quot : quot;
    diff = {s1_centre[mabr_pkg::SAMPLE_BITS-1], s1_centre} - mean;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_centre <= in_res.centre;
      s1_neg    <= in_res.sum[mabr_pkg::SUM_BITS-1];
      s1_prod   <= prod;
      s1_last   <= in_res.last_result;
    end
    if (s1_valid && out_free) begin
      res_item.corrected   <= diff;
      res_item.last_result <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        res_valid <= s1_valid;
      end
    end
  end

endmodule

/* src/moving_average_baseline_removal_core.sv */
// ----------------------------------------------------------------------------
// moving_average_baseline_removal_core: ECG baseline removal
// Subtracts a centred moving average over 2*HALF_WINDOW+1 samples from each
// sample of a record, replicating the first and last samples at the ends.
// ----------------------------------------------------------------------------
// Usage notes.
// Samples enter on the smp channel (valid/ready); each item carries a signed
// sample and an end_of_record flag. Results leave on the res channel; each
// item carries the corrected sample and a flag on the final result of the
// record. An item is taken on any edge where valid and ready are both high.
// Throughput is one item per cycle in both directions while res_ready is high
// and no record end is being flushed. The result for a sample appears once
// HALF_WINDOW later samples have been taken; that later item is written into
// the queue on its accepting edge and then passes the window stage, multiply
// stage and output register. The last item of a record starts a flush in
// which the window stage pushes the last sample HALF_WINDOW more times;
// during the flush the queue fills and smp_ready drops. When the receiver holds
// res_ready low the output register, multiply stage, window stage and
// two-entry queue fill in turn before smp_ready falls. Reset clears all
// control state; no clearing pass is needed, and the first sample after
// reset or after a record end starts a new record.
// ----------------------------------------------------------------------------
module moving_average_baseline_removal_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 smp_valid,
  output logic                 smp_ready,
  input  mabr_pkg::in_item_t   smp_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mabr_pkg::out_item_t  res_item
);

  // Front to queue.
  logic                 f_valid;
  logic                 f_ready;
  mabr_pkg::op_t        f_op;

  // Queue to window stage.
  logic                 q_valid;
  logic                 q_pop;
  mabr_pkg::op_t        q_op;

  // Window stage to divide stage.
  logic                 w_valid;
  logic                 w_ready;
  mabr_pkg::win_res_t   w_res;
  mabr_pkg::win_stat_t  win_stat;

  mabr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_item  (smp_item),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  mabr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_op),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_op)
  );

  // The window stage holds the delay line and running sum; it pops one item
  // per cycle when its output is free, and not while a record end is flushed.
  mabr_window u_window (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op        (q_op),
    .op_pop    (q_pop),
    .res_valid (w_valid),
    .res       (w_res),
    .res_ready (w_ready),
    .stat      (win_stat)
  );

  mabr_correct u_correct (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (w_valid),
    .in_ready  (w_ready),
    .in_res    (w_res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

`ifndef ASSERT_OFF
  // Nothing is offered on the result side right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // The queue is not drained while a record end is being flushed.
  a_no_pop_in_flush: assert property (@(posedge clk) disable iff (rst)
    win_stat.pop |-> !win_stat.flushing)
    else $error("item popped during flush");

  // The window stage only takes items that the queue holds.
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    win_stat.pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

/* tb/moving_average_baseline_removal_core_tb.sv */
// ----------------------------------------------------------------------------
// moving_average_baseline_removal_core_tb: self-checking bench for the core
// Sends records of ECG samples through the smp channel and checks every
// corrected sample on the res channel against a behavioral window model
// kept inside the bench. Both sides idle at random, except in one stretch.
// ----------------------------------------------------------------------------
module moving_average_baseline_removal_core_tb;

  localparam int ITEM_TOTAL = 130;

  typedef struct packed {
    mabr_pkg::in_item_t item;
    logic               hold;   // wait for every owed result before sending this item
  } pending_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 smp_valid = 1'b0;
  logic                 smp_ready;
  mabr_pkg::in_item_t   smp_item = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  mabr_pkg::out_item_t  res_item;

  pending_t             pending_samples[$];
  mabr_pkg::out_item_t  expected_results[$];
  mabr_pkg::out_item_t  want;

  // Bench copy of the sample history of the current record.
  logic signed [mabr_pkg::SAMPLE_BITS-1:0] win_hist[mabr_pkg::WIN_LEN];
  int rec_count = 0;
  int head_slot = 0;

  int  items_taken = 0;
  int  results_seen = 0;
  int  error_count = 0;
  int  record_total = 0;
  int  short_records = 0;
  int  record_len = 0;
  bit  hold_armed = 1'b0;
  logic quiet;

  moving_average_baseline_removal_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_item  (smp_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  always #1 clk = ~clk;

  // No random idling on either side while this window of items goes through.
  assign quiet = (items_taken >= 60) && (items_taken < 110);

  // Sample at a given age in the record, 0 being the newest. Ages past the
  // oldest sample read the oldest one, which replicates the record start.
  function automatic int hist_at(int age);
    int a;
    a = age < 0 ? 0 : age;
    if (a > rec_count - 1) a = rec_count - 1;
    return win_hist[(head_slot + mabr_pkg::WIN_LEN - a) % mabr_pkg::WIN_LEN];
  endfunction

  // Centre sample minus the truncated mean of its window. Negative ages
  // clamp to the newest sample, which replicates the record end.
  function automatic logic signed [mabr_pkg::SAMPLE_BITS:0] corrected_at(int centre);
    int total;
    total = 0;
    for (int d = -mabr_pkg::HALF_WINDOW; d <= mabr_pkg::HALF_WINDOW; d++)
      total += hist_at(centre - d);
    return (mabr_pkg::SAMPLE_BITS+1)'(hist_at(centre) - total / mabr_pkg::WIN_LEN);
  endfunction

  task automatic baseline_removal_predict(mabr_pkg::in_item_t it);
    int top;
    mabr_pkg::out_item_t r;
    head_slot = (rec_count != 0) ? (head_slot + 1) % mabr_pkg::WIN_LEN : 0;
    win_hist[head_slot] = it.sample;
    if (rec_count < mabr_pkg::WIN_LEN) rec_count++;
    if (!it.end_of_record) begin
      // Warm-up: nothing comes out until the centre has HALF_WINDOW successors.
      if (rec_count > mabr_pkg::HALF_WINDOW) begin
        r.corrected = corrected_at(mabr_pkg::HALF_WINDOW);
        r.last_result = 1'b0;
        expected_results = {expected_results, r};
      end
    end else begin
      // The record end flushes every pending centre, oldest first.
      top = (rec_count - 1 > mabr_pkg::HALF_WINDOW) ? mabr_pkg::HALF_WINDOW : rec_count - 1;
      for (int c = top; c >= 0; c--) begin
        r.corrected = corrected_at(c);
        r.last_result = (c == 0);
        expected_results = {expected_results, r};
      end
      rec_count = 0;
      head_slot = 0;
    end
  endtask

  task automatic queue_sample(logic signed [mabr_pkg::SAMPLE_BITS-1:0] s, bit eor, bit hold);
    pending_t p;
    p.item.sample = s;
    p.item.end_of_record = eor;
    p.hold = hold;
    pending_samples = {pending_samples, p};
    record_len++;
    if (eor) begin
      record_total++;
      if (record_len <= mabr_pkg::HALF_WINDOW) short_records++;
      record_len = 0;
    end
  endtask

  function automatic logic signed [mabr_pkg::SAMPLE_BITS-1:0] draw_sample(int style,
                                                                           int level);
    int v;
    case (style)
      0: return mabr_pkg::SAMPLE_BITS'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: begin
        v = level + int'($urandom_range(600)) - 300;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return mabr_pkg::SAMPLE_BITS'(v);
      end
    endcase
  endfunction

  // Driver: a new item goes out whenever the channel slot is free. An item
  // marked hold is first held back once, so the results of the record just
  // ended are on the expected list, then waits for that list to drain.
  always @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!smp_valid || smp_ready) begin
      if (pending_samples.size() == 0 || (!quiet && $urandom_range(99) < 7)) begin
        smp_valid <= 1'b0;
      end else if (pending_samples[0].hold &&
                   (!hold_armed || expected_results.size() != 0)) begin
        smp_valid <= 1'b0;
        hold_armed = 1'b1;
      end else begin
        smp_item  <= pending_samples[0].item;
        smp_valid <= 1'b1;
        void'(pending_samples.pop_front());
        hold_armed = 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    res_ready <= rst ? 1'b0 : (quiet || $urandom_range(99) >= 7);
  end

  // Monitor: checks a taken result against the oldest expectation before
  // predicting from a sample taken on the same edge, so a result can never
  // be matched against an expectation raised in that very cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got corrected %0d last %0b",
                   $time, res_item.corrected, res_item.last_result);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_item.corrected !== want.corrected) begin
            $display("%0t: corrected mismatch, expected %0d, got %0d",
                     $time, want.corrected, res_item.corrected);
            error_count++;
          end
          if (res_item.last_result !== want.last_result) begin
            $display("%0t: last_result mismatch, expected %0b, got %0b",
                     $time, want.last_result, res_item.last_result);
            error_count++;
          end
        end
      end
      if (smp_valid && smp_ready) begin
        baseline_removal_predict(smp_item);
        items_taken++;
      end
    end
  end

  initial begin
    int len;
    int style;
    int level;
    int kind;

    // Directed records. A single extreme sample is a record of its own.
    queue_sample(16'sh8000, 1'b1, 1'b0);
    // Two-sample record, opposite extremes; sent only after the first drains.
    queue_sample(16'sh7fff, 1'b0, 1'b1);
    queue_sample(16'sh8000, 1'b1, 1'b0);
    // Longest short record: HALF_WINDOW samples, all results on the last one.
    for (int i = 0; i < mabr_pkg::HALF_WINDOW; i++)
      queue_sample((i % 3 == 2) ? 16'sh0000 : (i[0] ? 16'sh8000 : 16'sh7fff),
                   i == mabr_pkg::HALF_WINDOW - 1, 1'b0);

    // Random records: short ones, ones right at the warm-up edge and long
    // ones of up to 70 samples, which can wrap the history buffer. The last
    // record is cut so the run holds ITEM_TOTAL items in all.
    while (pending_samples.size() < ITEM_TOTAL) begin
      kind = $urandom_range(9);
      if (kind < 3)      len = $urandom_range(1, mabr_pkg::HALF_WINDOW);
      else if (kind < 4) len = mabr_pkg::HALF_WINDOW + 1 + $urandom_range(1);
      else               len = $urandom_range(mabr_pkg::HALF_WINDOW + 3, 70);
      if (len > ITEM_TOTAL - pending_samples.size())
        len = ITEM_TOTAL - pending_samples.size();
      style = $urandom_range(5);
      level = int'($urandom_range(60000)) - 30000;
      for (int i = 0; i < len; i++) begin
        if (style >= 2) level += int'($urandom_range(200)) - 100;
        queue_sample(draw_sample(style > 2 ? 2 : style, level), i == len - 1,
                     i == 0 && (record_total == 3 || $urandom_range(99) < 15));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_samples.size() != 0 || smp_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d samples in %0d records (%0d no longer than the half window),",
             items_taken, record_total, short_records);
    $display("checked %0d corrected samples, %0d errors.", results_seen, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
